// ===== hdl/stop_string_stream_filter_core_defines.svh =====
// ----------------------------------------------------------------------------
// stop string stream filter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef STOP_STRING_STREAM_FILTER_CORE_DEFINES_SVH
`define STOP_STRING_STREAM_FILTER_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define SSSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sssf check failed");

// next-cycle implication, off while in reset
`define SSSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sssf check failed");

`endif

// ===== hdl/sssf_pkg.sv =====
// ----------------------------------------------------------------------------
// sssf_pkg
// types, codes and helpers shared by the stop string filter modules
// ----------------------------------------------------------------------------
package sssf_pkg;

  localparam int CountWidth = 4;
  typedef logic [CountWidth-1:0] count_t;

  // what closes a command after its held bytes
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_STOP,
    TAIL_END
  } tail_t;

  localparam logic [1:0] DONE_RUN  = 2'd0;
  localparam logic [1:0] DONE_STOP = 2'd1;
  localparam logic [1:0] DONE_END  = 2'd2;

  localparam logic REG_STOP_TEXT   = 1'b0;
  localparam logic REG_STOP_LENGTH = 1'b1;

  typedef struct packed {
    count_t     flush_count;
    tail_t      tail;
    logic [7:0] data_byte;
  } cmd_t;

  function automatic logic [7:0] stop_byte(input logic [63:0] text, input logic [2:0] pos);
    return text[{pos, 3'b000} +: 8];
  endfunction

endpackage

// ===== hdl/sssf_if.sv =====
// ----------------------------------------------------------------------------
// sssf interfaces
// input, output and configuration channels of the stop string filter
// ----------------------------------------------------------------------------
interface sssf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       source_ended;

  modport source (output valid, data_byte, source_ended, input ready);
  modport sink (input valid, data_byte, source_ended, output ready);
endinterface

interface sssf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] stream_done;
  logic       last;

  modport source (output valid, out_byte, byte_valid, stream_done, last, input ready);
  modport sink (input valid, out_byte, byte_valid, stream_done, last, output ready);
endinterface

interface sssf_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/sssf_front.sv =====
// ----------------------------------------------------------------------------
// sssf_front
// accepts source words, tracks the partial match, issues flush, byte and marker commands
// ----------------------------------------------------------------------------
module sssf_front #(
  parameter int MAX_STOP_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  sssf_in_if.sink           src,
  input  logic [63:0]       stop_text,
  input  sssf_pkg::count_t  stop_length,
  input  logic              queue_full,
  output logic              cmd_push,
  output sssf_pkg::cmd_t    cmd
);

  sssf_pkg::count_t match_position;
  sssf_pkg::count_t match_position_next;
  logic             finished;
  logic             finished_next;
  sssf_pkg::count_t used_len;
  sssf_pkg::count_t mp_base;
  sssf_pkg::count_t mp_inc;
  logic             hit_cur;
  logic             hit;
  logic             accept;

  assign src.ready = !queue_full;
  assign accept    = src.valid && src.ready;

  always_comb begin
    if (stop_length == '0) begin
      used_len = sssf_pkg::count_t'(1);
    end else if (stop_length > sssf_pkg::count_t'(MAX_STOP_BYTES)) begin
      used_len = sssf_pkg::count_t'(MAX_STOP_BYTES);
    end else begin
      used_len = stop_length;
    end
  end

  always_comb begin
    hit_cur = src.data_byte == sssf_pkg::stop_byte(stop_text, match_position[2:0]);
    mp_base = hit_cur ? match_position : '0;
    hit     = hit_cur || (src.data_byte == sssf_pkg::stop_byte(stop_text, 3'd0));
    mp_inc  = mp_base + sssf_pkg::count_t'(1);

    cmd.data_byte       = src.data_byte;
    cmd.flush_count     = hit_cur ? '0 : match_position;
    cmd.tail            = sssf_pkg::TAIL_NONE;
    match_position_next = match_position;
    finished_next       = finished;

    if (src.source_ended) begin
      cmd.flush_count     = match_position;
      cmd.tail            = sssf_pkg::TAIL_END;
      match_position_next = '0;
      finished_next       = 1'b1;
    end else if (hit) begin
      if (mp_inc >= used_len) begin
        cmd.tail            = sssf_pkg::TAIL_STOP;
        match_position_next = '0;
        finished_next       = 1'b1;
      end else begin
        match_position_next = mp_inc;
      end
    end else begin
      cmd.tail            = sssf_pkg::TAIL_BYTE;
      match_position_next = '0;
    end

    // held bytes with nothing to flush give no command
    cmd_push = accept && !finished &&
               ((cmd.flush_count != '0) || (cmd.tail != sssf_pkg::TAIL_NONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_position <= '0;
      finished       <= 1'b0;
    end else if (accept && !finished) begin
      match_position <= match_position_next;
      finished       <= finished_next;
    end
  end

endmodule

// ===== hdl/sssf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// sssf_cmd_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module sssf_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sssf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sssf_pkg::cmd_t head
);

  sssf_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/sssf_back.sv =====
// ----------------------------------------------------------------------------
// sssf_back
// expands commands into output words through a registered output stage
// ----------------------------------------------------------------------------
module sssf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    stop_text,
  input  logic           head_valid,
  input  sssf_pkg::cmd_t head,
  output logic           pop,
  sssf_out_if.source     dst
);

  sssf_pkg::count_t idx;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic [1:0]       stream_done;
  logic             last;
  logic [7:0]       w_byte;
  logic             w_byte_valid;
  logic [1:0]       w_done;
  logic             w_last;
  logic             load;

  assign load = head_valid && (!out_valid || dst.ready);
  assign pop  = load && w_last;

  always_comb begin
    if (idx != head.flush_count) begin
      // held stop bytes first
      w_byte       = sssf_pkg::stop_byte(stop_text, idx[2:0]);
      w_byte_valid = 1'b1;
      w_done       = sssf_pkg::DONE_RUN;
      w_last       = (idx + sssf_pkg::count_t'(1) == head.flush_count) &&
                     (head.tail == sssf_pkg::TAIL_NONE);
    end else begin
      w_last = 1'b1;
      case (head.tail)
        sssf_pkg::TAIL_STOP: begin
          w_byte       = 8'd0;
          w_byte_valid = 1'b0;
          w_done       = sssf_pkg::DONE_STOP;
        end
        sssf_pkg::TAIL_END: begin
          w_byte       = 8'd0;
          w_byte_valid = 1'b0;
          w_done       = sssf_pkg::DONE_END;
        end
        default: begin
          w_byte       = head.data_byte;
          w_byte_valid = 1'b1;
          w_done       = sssf_pkg::DONE_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= w_last ? '0 : idx + sssf_pkg::count_t'(1);
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= w_byte;
      byte_valid  <= w_byte_valid;
      stream_done <= w_done;
      last        <= w_last;
    end
  end

  assign dst.valid       = out_valid;
  assign dst.out_byte    = out_byte;
  assign dst.byte_valid  = byte_valid;
  assign dst.stream_done = stream_done;
  assign dst.last        = last;

endmodule

// ===== hdl/stop_string_stream_filter_core.sv =====
// ----------------------------------------------------------------------------
// stop_string_stream_filter_core
// byte stream filter that ends the stream at a configured stop string
// ----------------------------------------------------------------------------
// passes source bytes to dst until the stop string (stop_text, first byte in
// bits 7:0, stop_length bytes long, 0 taken as 1, clamped to MAX_STOP_BYTES)
// is seen, then gives one stop marker word and ignores all later input until
// reset. bytes matching a prefix of the stop string are held back; on a
// mismatch they are flushed and the current byte is retested from the first
// stop byte (plain restart matching). a word with source_ended set flushes
// what is held and gives an end marker. the last word caused by an input word
// carries last. timing: the front accepts one input word per cycle while the
// two-entry command queue has room; the back emits one output word per cycle
// while dst is ready, and an input word causes up to MAX_STOP_BYTES output
// words (at most MAX_STOP_BYTES - 1 held bytes plus one tail word). the back's
// one-word-per-cycle expansion, while dst is ready, sets the sustained rate.
// configuration is taken at any time, one write a cycle, and is meant to
// change only while the filter is idle.
// ----------------------------------------------------------------------------
module stop_string_stream_filter_core #(
  parameter int MAX_STOP_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  sssf_cfg_if.sink    cfg,
  sssf_in_if.sink     src,
  sssf_out_if.source  dst
);

  // configuration registers
  logic [63:0]      stop_text;
  sssf_pkg::count_t stop_length;

  // front to queue
  logic             cmd_push;
  sssf_pkg::cmd_t   cmd;
  logic             queue_full;

  // queue to back
  logic             head_valid;
  sssf_pkg::cmd_t   head;
  logic             pop;

  // register writes never stall
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_text   <= '0;
      stop_length <= sssf_pkg::count_t'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        sssf_pkg::REG_STOP_TEXT:   stop_text   <= cfg.data;
        sssf_pkg::REG_STOP_LENGTH: stop_length <= cfg.data[sssf_pkg::CountWidth-1:0];
        default:                   stop_text   <= stop_text;
      endcase
    end
  end

  // front: match tracking and command issue
  sssf_front #(
    .MAX_STOP_BYTES (MAX_STOP_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .src         (src),
    .stop_text   (stop_text),
    .stop_length (stop_length),
    .queue_full  (queue_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  // decouples front stalls from output back-pressure
  sssf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: flush held bytes, then the tail word if the command has one
  sssf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .stop_text  (stop_text),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .dst        (dst)
  );

endmodule

// ===== hdl/sssf_checker.sv =====
// ----------------------------------------------------------------------------
// sssf_checker
// port-level checks of the stop string filter output channel
// ----------------------------------------------------------------------------
`include "stop_string_stream_filter_core_defines.svh"

module sssf_checker (
  input logic       clk,
  input logic       rst,
  input logic       dst_valid,
  input logic       dst_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [1:0] stream_done,
  input logic       last
);

  `SSSF_ASSERT_NEXT(a_stall_hold, dst_valid && !dst_ready, dst_valid && $stable(out_byte) && $stable(byte_valid) && $stable(stream_done) && $stable(last))
  `SSSF_ASSERT_NOW(a_marker_last, dst_valid && !byte_valid, last && (stream_done != sssf_pkg::DONE_RUN))
  `SSSF_ASSERT_NOW(a_byte_running, dst_valid && byte_valid, stream_done == sssf_pkg::DONE_RUN)
  `SSSF_ASSERT_NEXT(a_quiet_after_marker, dst_valid && dst_ready && !byte_valid, !dst_valid)

endmodule

bind stop_string_stream_filter_core sssf_checker u_sssf_checker (
  .clk         (clk),
  .rst         (rst),
  .dst_valid   (dst.valid),
  .dst_ready   (dst.ready),
  .out_byte    (dst.out_byte),
  .byte_valid  (dst.byte_valid),
  .stream_done (dst.stream_done),
  .last        (dst.last)
);
